### rtl/core/assert_macros.svh
// assertion helpers shared by the packer modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequence must hold in the same cycle as the antecedent
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle check");

// consequence must hold in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle check");

`endif

### rtl/core/lsbp_pkg.sv
package lsbp_pkg;

	// fixed field widths
	localparam int unsigned ACTION_W = 1;
	localparam int unsigned VALUE_W  = 32;
	localparam int unsigned WIDTH_W  = 6;
	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned PEND_W   = 3;

	// action codes
	localparam logic [ACTION_W-1:0] ACT_APPEND = 1'b0;
	localparam logic [ACTION_W-1:0] ACT_ALIGN  = 1'b1;

	// controller states
	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EMIT = 2'b10
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic shift;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic has_bytes;
		logic last;
	} status_t;

endpackage

### rtl/core/lsbp_if.sv
// input item channel
interface lsbp_in_if;
	logic                                valid;
	logic                                ready;
	logic [lsbp_pkg::ACTION_W-1:0]       action;
	logic [lsbp_pkg::VALUE_W-1:0]        field_value;
	logic [lsbp_pkg::WIDTH_W-1:0]        field_width;

	modport source (output valid, action, field_value, field_width, input ready);
	modport sink (input valid, action, field_value, field_width, output ready);
endinterface

// output byte channel
interface lsbp_out_if;
	logic                              valid;
	logic                              ready;
	logic [lsbp_pkg::BYTE_W-1:0]       packed_byte;
	logic                              last_of_run;

	modport source (output valid, packed_byte, last_of_run, input ready);
	modport sink (input valid, packed_byte, last_of_run, output ready);
endinterface

### rtl/core/lsbp_ctrl.sv
`include "assert_macros.svh"

module lsbp_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              out_ready,
	input  lsbp_pkg::status_t status,
	output logic              in_ready,
	output logic              out_valid,
	output lsbp_pkg::cmd_t    cmd
);

	lsbp_pkg::state_t state_q;
	lsbp_pkg::state_t state_nxt;

	// handshake outputs follow the state register
	assign in_ready  = (state_q == lsbp_pkg::ST_IDLE);
	assign out_valid = (state_q == lsbp_pkg::ST_EMIT);
	assign cmd.load  = in_valid && in_ready;
	assign cmd.shift = out_valid && out_ready;

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			lsbp_pkg::ST_IDLE: begin
				if (cmd.load && status.has_bytes) begin
					state_nxt = lsbp_pkg::ST_EMIT;
				end
			end
			lsbp_pkg::ST_EMIT: begin
				if (cmd.shift && status.last) begin
					state_nxt = lsbp_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = lsbp_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lsbp_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// an item that completes a byte must start emitting
	`ASSERT_NEXT(a_load_to_emit, clk, arst_n, cmd.load && status.has_bytes, out_valid)
	// an item that completes nothing leaves the block ready
	`ASSERT_NEXT(a_load_no_bytes, clk, arst_n, cmd.load && !status.has_bytes, in_ready)
	// final byte transfer returns to idle
	`ASSERT_NEXT(a_last_to_idle, clk, arst_n, cmd.shift && status.last, in_ready)

endmodule

### rtl/core/lsbp_datapath.sv
`include "assert_macros.svh"

module lsbp_datapath #(
	parameter int unsigned MAX_FIELD_BITS = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  lsbp_pkg::cmd_t                    cmd,
	input  logic [lsbp_pkg::ACTION_W-1:0]     action,
	input  logic [lsbp_pkg::VALUE_W-1:0]      field_value,
	input  logic [lsbp_pkg::WIDTH_W-1:0]      field_width,
	output lsbp_pkg::status_t                 status,
	output logic [lsbp_pkg::BYTE_W-1:0]       packed_byte,
	output logic                              last_of_run
);

	localparam int unsigned ACC_W = MAX_FIELD_BITS + 7;
	localparam int unsigned VAL_W = (MAX_FIELD_BITS < lsbp_pkg::VALUE_W) ?
		MAX_FIELD_BITS : lsbp_pkg::VALUE_W;
	localparam int unsigned TOT_W = $clog2(ACC_W + 1);
	localparam int unsigned NB_W  = TOT_W - 3;

	logic [ACC_W-1:0]                acc_q;
	logic [lsbp_pkg::PEND_W-1:0]     cnt_q;
	logic [NB_W-1:0]                 rem_q;

	logic [lsbp_pkg::WIDTH_W-1:0]    eff_w;
	logic [VAL_W-1:0]                val_mask;
	logic [VAL_W-1:0]                val_lo;
	logic [ACC_W-1:0]                app_acc;
	logic [TOT_W-1:0]                total;
	logic [NB_W-1:0]                 nbytes;
	logic                            is_align;

	// saturate width and mask off value bits above it
	always_comb begin
		if (field_width > lsbp_pkg::WIDTH_W'(MAX_FIELD_BITS)) begin
			eff_w = lsbp_pkg::WIDTH_W'(MAX_FIELD_BITS);
		end else begin
			eff_w = field_width;
		end
		if (eff_w >= lsbp_pkg::WIDTH_W'(VAL_W)) begin
			val_mask = '1;
		end else begin
			val_mask = ({{(VAL_W-1){1'b0}}, 1'b1} << eff_w) - {{(VAL_W-1){1'b0}}, 1'b1};
		end
		val_lo = field_value[VAL_W-1:0] & val_mask;
	end

	// append after the pending bits
	assign app_acc  = acc_q | ({{(ACC_W-VAL_W){1'b0}}, val_lo} << cnt_q);
	assign total    = TOT_W'(cnt_q) + TOT_W'(eff_w);
	assign nbytes   = total[TOT_W-1:3];
	assign is_align = (action == lsbp_pkg::ACT_ALIGN);

	// status to controller
	assign status.has_bytes = is_align ? (cnt_q != '0) : (nbytes != '0);
	assign status.last      = (rem_q == NB_W'(1));

	// byte output comes straight from the accumulator
	assign packed_byte = acc_q[lsbp_pkg::BYTE_W-1:0];
	assign last_of_run = status.last;

	// accumulator, pending count and bytes left
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			cnt_q <= '0;
			rem_q <= '0;
		end else if (cmd.load) begin
			if (is_align) begin
				rem_q <= (cnt_q != '0) ? NB_W'(1) : '0;
				cnt_q <= '0;
			end else begin
				acc_q <= app_acc;
				cnt_q <= total[lsbp_pkg::PEND_W-1:0];
				rem_q <= nbytes;
			end
		end else if (cmd.shift) begin
			acc_q <= acc_q >> lsbp_pkg::BYTE_W;
			rem_q <= rem_q - NB_W'(1);
		end
	end

	// with no bytes left, nothing sits above the pending bits
	`ASSERT_SAME(a_pending_clean, clk, arst_n, rem_q == '0, (acc_q >> cnt_q) == ACC_W'(0))
	// a non-final transfer counts down by one
	`ASSERT_NEXT(a_rem_count, clk, arst_n, cmd.shift && !status.last, rem_q == $past(rem_q) - NB_W'(1))
	// transfers only while bytes are left
	`ASSERT_SAME(a_shift_has_rem, clk, arst_n, cmd.shift, rem_q != '0)

endmodule

### rtl/core/lsb_first_bit_packer_top.sv
// channel    dir  handshake     payload
// item_in    in   valid/ready   action, field_value, field_width
// byte_out   out  valid/ready   packed_byte, last_of_run
//
// an item is taken while item_in is ready, then its n bytes leave one per cycle while byte_out is ready,
// n = 0 .. (7 + MAX_FIELD_BITS) / 8 (0 .. 4 by default)
// the single accumulator register shifts one byte per transfer
// item_in is ready only while no bytes of the previous item remain
// byte_out stalls hold the accumulator and the byte count
// reset clears the pending bits and returns to idle

module lsb_first_bit_packer_top #(
	parameter int unsigned MAX_FIELD_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	lsbp_in_if.sink     item_in,
	lsbp_out_if.source  byte_out
);

	lsbp_pkg::cmd_t    cmd;
	lsbp_pkg::status_t status;

	// sequencing
	lsbp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item_in.valid),
		.out_ready (byte_out.ready),
		.status    (status),
		.in_ready  (item_in.ready),
		.out_valid (byte_out.valid),
		.cmd       (cmd)
	);

	// bit accumulation and byte output
	lsbp_datapath #(
		.MAX_FIELD_BITS (MAX_FIELD_BITS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.action      (item_in.action),
		.field_value (item_in.field_value),
		.field_width (item_in.field_width),
		.status      (status),
		.packed_byte (byte_out.packed_byte),
		.last_of_run (byte_out.last_of_run)
	);

endmodule

### tb/tb_lsb_first_bit_packer_top.sv
`timescale 1ns / 1ps

module tb_lsb_first_bit_packer_top;

	localparam int unsigned FIELD_MAX_BITS = 32;
	localparam int unsigned QUIET_LIMIT    = 2000;

	// one byte owed by the packer
	typedef struct packed {
		logic [lsbp_pkg::BYTE_W-1:0] data;
		logic                        last;
	} owed_byte_t;

	logic clk;
	logic arst_n;

	lsbp_in_if  item_in();
	lsbp_out_if byte_out();

	lsb_first_bit_packer_top #(
		.MAX_FIELD_BITS(FIELD_MAX_BITS)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.item_in (item_in),
		.byte_out(byte_out)
	);

	// predicted stream state
	logic [6:0]                  held_bits;
	logic [lsbp_pkg::PEND_W-1:0] held_count;
	owed_byte_t                  owed_bytes[$];

	int unsigned error_count;
	int unsigned byte_index;
	int unsigned quiet_cycles;
	int unsigned src_gap_max;
	int unsigned sink_gap_max;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	task automatic report_mismatch(input string what);
		error_count++;
		$display("mismatch at %0t: %s", $realtime, what);
	endtask

	// expected bytes for one accepted item, updates the held bits
	function automatic void pack_field(input logic [lsbp_pkg::ACTION_W-1:0] act,
			input logic [lsbp_pkg::VALUE_W-1:0] value,
			input logic [lsbp_pkg::WIDTH_W-1:0] width);
		logic [63:0]  acc;
		logic [63:0]  mask;
		int unsigned  w;
		int unsigned  total;
		int unsigned  nbytes;
		int unsigned  rem;
		owed_byte_t   ob;
		if (act == lsbp_pkg::ACT_ALIGN) begin
			if (held_count != 0) begin
				ob.data = {1'b0, held_bits};
				ob.last = 1'b1;
				owed_bytes.push_back(ob);
				held_bits  = '0;
				held_count = '0;
			end
			return;
		end
		// oversized widths saturate, zero width is a no-op
		w = (width > FIELD_MAX_BITS) ? FIELD_MAX_BITS : width;
		if (w == 0)
			return;
		mask  = (64'd1 << w) - 64'd1;
		acc   = 64'(held_bits) | ((64'(value) & mask) << held_count);
		total = held_count + w;
		nbytes = total / 8;
		for (int unsigned k = 0; k < nbytes; k++) begin
			ob.data = acc[8*k +: 8];
			ob.last = (k + 1 == nbytes);
			owed_bytes.push_back(ob);
		end
		rem        = total % 8;
		acc        = (acc >> (8 * nbytes)) & ((64'd1 << rem) - 64'd1);
		held_bits  = acc[6:0];
		held_count = rem[lsbp_pkg::PEND_W-1:0];
	endfunction

	// one input transfer, valid stays high afterwards
	task automatic send_item(input logic [lsbp_pkg::ACTION_W-1:0] act,
			input logic [lsbp_pkg::VALUE_W-1:0] value,
			input logic [lsbp_pkg::WIDTH_W-1:0] width);
		int unsigned gap;
		gap = $urandom_range(0, src_gap_max);
		if (gap > 0) begin
			item_in.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_in.valid       <= 1'b1;
		item_in.action      <= act;
		item_in.field_value <= value;
		item_in.field_width <= width;
		do @(posedge clk); while (!item_in.ready);
		pack_field(act, value, width);
	endtask

	task automatic send_random_item();
		int unsigned                  pick;
		logic [lsbp_pkg::WIDTH_W-1:0] w;
		pick = $urandom_range(0, 99);
		if (pick < 15) begin
			send_item(lsbp_pkg::ACT_ALIGN, $urandom(),
				lsbp_pkg::WIDTH_W'($urandom_range(0, 63)));
		end else begin
			if (pick < 20)
				w = '0;
			else if (pick < 27)
				w = lsbp_pkg::WIDTH_W'($urandom_range(FIELD_MAX_BITS + 1, 63));
			else
				w = lsbp_pkg::WIDTH_W'($urandom_range(1, FIELD_MAX_BITS));
			send_item(lsbp_pkg::ACT_APPEND, $urandom(), w);
		end
	endtask

	// hold the sender off until every owed byte has come out
	task automatic wait_drained();
		item_in.valid <= 1'b0;
		@(posedge clk);
		while (owed_bytes.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_directed_edges();
		src_gap_max  = 2;
		sink_gap_max = 2;
		// align with nothing pending
		send_item(lsbp_pkg::ACT_ALIGN, 32'h0, 6'd0);
		send_item(lsbp_pkg::ACT_APPEND, 32'h1, 6'd1);
		// excess value bits must be masked
		send_item(lsbp_pkg::ACT_APPEND, 32'hFFFF_FFFF, 6'd3);
		send_item(lsbp_pkg::ACT_ALIGN, 32'hFFFF_FFFF, 6'd63);
		// zero width
		send_item(lsbp_pkg::ACT_APPEND, 32'hFFFF_FFFF, 6'd0);
		send_item(lsbp_pkg::ACT_APPEND, 32'hFFFF_FFFF, 6'd32);
		send_item(lsbp_pkg::ACT_APPEND, 32'h0, 6'd32);
		// seven bits pending, then a full field
		send_item(lsbp_pkg::ACT_APPEND, 32'h0000_0055, 6'd7);
		send_item(lsbp_pkg::ACT_APPEND, 32'hA5A5_A5A5, 6'd32);
		// widths above the maximum saturate
		send_item(lsbp_pkg::ACT_APPEND, 32'hFFFF_FFFF, 6'd63);
		send_item(lsbp_pkg::ACT_APPEND, 32'h1234_5678, 6'd33);
		send_item(lsbp_pkg::ACT_APPEND, 32'hFFFF_FF3C, 6'd8);
		send_item(lsbp_pkg::ACT_ALIGN, 32'h0, 6'd5);
		send_item(lsbp_pkg::ACT_ALIGN, 32'h0, 6'd0);
		// appends that complete no byte, then ones that do
		send_item(lsbp_pkg::ACT_APPEND, 32'hFFFF_FFE5, 6'd5);
		send_item(lsbp_pkg::ACT_APPEND, 32'h0000_0002, 6'd2);
		send_item(lsbp_pkg::ACT_APPEND, 32'h0000_0001, 6'd1);
		send_item(lsbp_pkg::ACT_APPEND, 32'h8000_0001, 6'd31);
		send_item(lsbp_pkg::ACT_APPEND, 32'h0000_0000, 6'd16);
		send_item(lsbp_pkg::ACT_ALIGN, 32'hFFFF_FFFF, 6'd32);
	endtask

	task automatic test_drain_pause();
		src_gap_max  = 12;
		sink_gap_max = 12;
		repeat (4) send_random_item();
		wait_drained();
		repeat (4) send_random_item();
		wait_drained();
	endtask

	task automatic test_random_idle();
		src_gap_max  = 12;
		sink_gap_max = 12;
		repeat (100) send_random_item();
	endtask

	task automatic test_random_burst();
		src_gap_max  = 0;
		sink_gap_max = 0;
		repeat (70) send_random_item();
	endtask

	task automatic test_random_backpressure();
		src_gap_max  = 0;
		sink_gap_max = 12;
		repeat (60) send_random_item();
	endtask

	task automatic test_random_starve();
		src_gap_max  = 12;
		sink_gap_max = 0;
		repeat (50) send_random_item();
	endtask

	// byte sink with random stalls
	initial begin
		int unsigned stall;
		forever begin
			stall = $urandom_range(0, sink_gap_max);
			if (stall > 0) begin
				byte_out.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			byte_out.ready <= 1'b1;
			do @(posedge clk); while (!byte_out.valid);
		end
	end

	// compare each byte transfer with the oldest owed byte
	always @(posedge clk) begin
		owed_byte_t want;
		if (arst_n && byte_out.valid && byte_out.ready) begin
			if (owed_bytes.size() == 0) begin
				report_mismatch($sformatf("byte %0d: unexpected byte %h",
					byte_index, byte_out.packed_byte));
			end else begin
				want = owed_bytes.pop_front();
				if (byte_out.packed_byte !== want.data)
					report_mismatch($sformatf("byte %0d: packed_byte %h, want %h",
						byte_index, byte_out.packed_byte, want.data));
				if (byte_out.last_of_run !== want.last)
					report_mismatch($sformatf("byte %0d: last_of_run %b, want %b",
						byte_index, byte_out.last_of_run, want.last));
			end
			byte_index++;
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((item_in.valid && item_in.ready) || (byte_out.valid && byte_out.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("timeout: no transfer for %0d cycles", quiet_cycles);
			$display("FAIL lsb_first_bit_packer_top");
			$finish;
		end
	end

	initial begin
		error_count  = 0;
		byte_index   = 0;
		quiet_cycles = 0;
		src_gap_max  = 0;
		sink_gap_max = 0;
		held_bits    = '0;
		held_count   = '0;
		arst_n              <= 1'b0;
		item_in.valid       <= 1'b0;
		item_in.action      <= lsbp_pkg::ACT_APPEND;
		item_in.field_value <= '0;
		item_in.field_width <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_edges();
		test_drain_pause();
		test_random_idle();
		test_random_burst();
		test_random_backpressure();
		test_random_starve();

		wait_drained();
		repeat (8) @(posedge clk);
		if (error_count == 0) begin
			$display("PASS lsb_first_bit_packer_top");
		end else begin
			$display("FAIL lsb_first_bit_packer_top");
		end
		$finish;
	end

endmodule
